@@ rtl/core/stun_message_parser_top_defines.svh @@
// Assertion macros used by the checker file of the STUN parser.
`ifndef STUN_MESSAGE_PARSER_TOP_DEFINES_SVH
`define STUN_MESSAGE_PARSER_TOP_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define STUN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define STUN_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/stun_pkg.sv @@
package stun_pkg;

  localparam int TDATA_W     = 120;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [16:0] HDR_LEN   = 17'd20;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [31:0] COOKIE    = 32'h2112A442;
  localparam logic [15:0] RSV_MASK  = 16'hC000;

  localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h8020;
  localparam logic [15:0] ATTR_FAMILY_ONLY = 16'h0016;

  localparam logic [2:0] VERDICT_OK    = 3'd0;
  localparam logic [2:0] VERDICT_SHORT = 3'd1;
  localparam logic [2:0] VERDICT_HDR   = 3'd2;
  localparam logic [2:0] VERDICT_TYPE  = 3'd3;
  localparam logic [2:0] VERDICT_LEN   = 3'd4;

  localparam logic KIND_ATTR    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [15:0] KNOWN_TYPES [16] = '{
    16'h0001, 16'h0101, 16'h0111, 16'h0002, 16'h0102, 16'h0112, 16'h0003, 16'h0103,
    16'h0113, 16'h0004, 16'h0104, 16'h0114, 16'h0115, 16'h0006, 16'h0106, 16'h0116
  };

  // One queue entry: what a single input byte caused.
  typedef struct packed {
    logic        has_attr;
    logic        has_verdict;
    logic        bogus;
    logic [2:0]  verdict;
    logic [15:0] mtype;
    logic [15:0] attr_type;
    logic [15:0] attr_length;
    logic [63:0] value;
    logic [31:0] txid;
  } stun_evt_t;

  function automatic logic is_known_type(input logic [15:0] t);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (KNOWN_TYPES[i] == t) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic is_addr_attr(input logic [15:0] t);
    return t == 16'h0001 || t == 16'h0002 || t == 16'h0004 || t == 16'h0005 ||
           t == 16'h000B || t == 16'h000E || t == 16'h0011 || t == 16'h0012 ||
           t == ATTR_XOR_MAPPED;
  endfunction

  // Pack one result, first field in the lowest bits.
  function automatic logic [TDATA_W-1:0] pack_result(
    input logic [2:0]  verdict,
    input logic [15:0] mtype,
    input logic [15:0] attr_type,
    input logic [15:0] attr_length,
    input logic        bogus,
    input logic [7:0]  family,
    input logic [15:0] port,
    input logic [31:0] ipv4,
    input logic [2:0]  addr_valid
  );
    return {7'd0, addr_valid, ipv4, port, family, bogus, attr_length, attr_type,
            mtype[8], mtype[4], mtype, verdict};
  endfunction

endpackage

@@ rtl/core/stun_front.sv @@
module stun_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  logic                q_full,
  output logic                push,
  output stun_pkg::stun_evt_t evt
);
  import stun_pkg::*;

  logic [16:0] byte_count, byte_count_next;
  logic [15:0] header_type, header_type_next;
  logic [15:0] header_length, header_length_next;
  logic [31:0] txid, txid_next;
  logic [15:0] rem_len, rem_len_next;
  logic [16:0] attr_idx, attr_idx_next;
  logic [15:0] cur_type, cur_type_next;
  logic [15:0] cur_len, cur_len_next;
  logic [63:0] value_cap, value_cap_next;
  logic [2:0]  reject_code, reject_code_next;
  logic        walk_stopped, walk_stopped_next;

  logic        take;
  logic        has_attr, has_verdict, bogus;
  logic [2:0]  verdict_code;
  logic [16:0] total_len;
  logic [2:0]  lane;

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    byte_count_next    = byte_count;
    header_type_next   = header_type;
    header_length_next = header_length;
    txid_next          = txid;
    rem_len_next       = rem_len;
    attr_idx_next      = attr_idx;
    cur_type_next      = cur_type;
    cur_len_next       = cur_len;
    value_cap_next     = value_cap;
    reject_code_next   = reject_code;
    walk_stopped_next  = walk_stopped;
    has_attr           = 1'b0;
    has_verdict        = 1'b0;
    bogus              = 1'b0;
    verdict_code       = VERDICT_OK;
    total_len          = 17'd4 + {1'b0, cur_len_next};
    lane               = 3'd7 - (attr_idx[2:0] - 3'd4);

    if (take) begin
      if (byte_count != COUNT_MAX) byte_count_next = byte_count + 17'd1;

      // Capture the header words.
      if (byte_count == 17'd0) header_type_next = {s_tdata, 8'h00};
      else if (byte_count == 17'd1) header_type_next = {header_type[15:8], s_tdata};
      else if (byte_count == 17'd2) header_length_next = {s_tdata, 8'h00};
      else if (byte_count == 17'd3) header_length_next = {header_length[15:8], s_tdata};
      else if (byte_count < 17'd8) txid_next = {txid[23:0], s_tdata};

      if (byte_count == HDR_LEN - 17'd1) begin
        if ((header_type & RSV_MASK) != 16'd0 || txid == COOKIE) begin
          reject_code_next = VERDICT_HDR;
        end else if (!is_known_type(header_type)) begin
          reject_code_next = VERDICT_TYPE;
        end else begin
          reject_code_next = VERDICT_OK;
        end
        walk_stopped_next = (reject_code_next != VERDICT_OK);
        rem_len_next      = header_length;
        attr_idx_next     = 17'd0;
      end else if (byte_count >= HDR_LEN && !walk_stopped && rem_len != 16'd0) begin
        case (attr_idx)
          17'd0: begin
            cur_type_next = {s_tdata, 8'h00};
            cur_len_next  = 16'd0;
          end
          17'd1: cur_type_next = {cur_type[15:8], s_tdata};
          17'd2: cur_len_next  = {s_tdata, 8'h00};
          17'd3: cur_len_next  = {cur_len[15:8], s_tdata};
          default: ;
        endcase
        total_len = 17'd4 + {1'b0, cur_len_next};

        if (rem_len < 16'd4 && (attr_idx + 17'd1) == {1'b0, rem_len}) begin
          // attribute header cut short by the message end
          has_attr          = 1'b1;
          bogus             = 1'b1;
          walk_stopped_next = 1'b1;
        end else if (attr_idx == 17'd3) begin
          if (total_len > {1'b0, rem_len}) begin
            has_attr          = 1'b1;
            bogus             = 1'b1;
            walk_stopped_next = 1'b1;
          end else if (cur_len_next == 16'd0) begin
            value_cap_next = '0;
            has_attr       = 1'b1;
            rem_len_next   = rem_len - 16'd4;
            attr_idx_next  = 17'd0;
          end else begin
            value_cap_next = '0;
            attr_idx_next  = 17'd4;
          end
        end else if (attr_idx >= 17'd4) begin
          if (attr_idx < 17'd12) value_cap_next[{lane, 3'b000} +: 8] = s_tdata;
          if (attr_idx == 17'd3 + {1'b0, cur_len}) begin
            has_attr      = 1'b1;
            rem_len_next  = rem_len - cur_len - 16'd4;
            attr_idx_next = 17'd0;
          end else begin
            attr_idx_next = attr_idx + 17'd1;
          end
        end else begin
          attr_idx_next = attr_idx + 17'd1;
        end
      end

      if (s_tlast) begin
        has_verdict = 1'b1;
        if (byte_count_next < HDR_LEN) begin
          verdict_code = VERDICT_SHORT;
        end else if (reject_code_next != VERDICT_OK) begin
          verdict_code = reject_code_next;
        end else if (byte_count_next != HDR_LEN + {1'b0, header_length_next}) begin
          verdict_code = VERDICT_LEN;
        end else begin
          verdict_code = VERDICT_OK;
        end
      end
    end
  end

  assign push             = take && (has_attr || has_verdict);
  assign evt.has_attr     = has_attr;
  assign evt.has_verdict  = has_verdict;
  assign evt.bogus        = bogus;
  assign evt.verdict      = verdict_code;
  assign evt.mtype        = header_type_next;
  assign evt.attr_type    = cur_type_next;
  assign evt.attr_length  = cur_len_next;
  assign evt.value        = value_cap_next;
  assign evt.txid         = txid_next;

  always_ff @(posedge clk) begin
    if (rst || (take && s_tlast)) begin
      byte_count    <= '0;
      header_type   <= '0;
      header_length <= '0;
      txid          <= '0;
      rem_len       <= '0;
      attr_idx      <= '0;
      cur_type      <= '0;
      cur_len       <= '0;
      value_cap     <= '0;
      reject_code   <= VERDICT_OK;
      walk_stopped  <= 1'b0;
    end else begin
      byte_count    <= byte_count_next;
      header_type   <= header_type_next;
      header_length <= header_length_next;
      txid          <= txid_next;
      rem_len       <= rem_len_next;
      attr_idx      <= attr_idx_next;
      cur_type      <= cur_type_next;
      cur_len       <= cur_len_next;
      value_cap     <= value_cap_next;
      reject_code   <= reject_code_next;
      walk_stopped  <= walk_stopped_next;
    end
  end

endmodule

@@ rtl/core/stun_queue.sv @@
module stun_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  stun_pkg::stun_evt_t evt_in,
  input  logic                pop,
  output stun_pkg::stun_evt_t evt_out,
  output logic                empty,
  output logic                full
);
  import stun_pkg::*;

  stun_evt_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty   = (count == '0);
  assign full    = (count == QUEUE_DEPTH[QPTR_W:0]);
  assign evt_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= evt_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ rtl/core/stun_back.sv @@
module stun_back (
  input  logic                         clk,
  input  logic                         rst,
  input  stun_pkg::stun_evt_t          evt,
  input  logic                         empty,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [stun_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tuser,
  output logic                         m_tlast
);
  import stun_pkg::*;

  logic              load;
  logic              pend_verdict;
  logic [15:0]       pend_type;
  logic [2:0]        pend_code;
  logic              addr_attr, fam_attr, xor_attr;
  logic [7:0]        family;
  logic [15:0]       port;
  logic [31:0]       ipv4;
  logic [2:0]        addr_valid;
  logic [TDATA_W-1:0] attr_beat, evt_verdict_beat, pend_verdict_beat;

  assign load = !m_tvalid || m_tready;
  assign pop  = load && !pend_verdict && !empty;

  // Decode the address fields of the attribute at the queue head.
  always_comb begin
    addr_attr  = is_addr_attr(evt.attr_type) && !evt.bogus;
    fam_attr   = (addr_attr || evt.attr_type == ATTR_FAMILY_ONLY) && !evt.bogus;
    xor_attr   = evt.attr_type == ATTR_XOR_MAPPED;
    family     = 8'd0;
    port       = 16'd0;
    ipv4       = 32'd0;
    addr_valid = 3'd0;
    if (fam_attr && evt.attr_length >= 16'd2) begin
      family        = evt.value[55:48];
      addr_valid[0] = 1'b1;
    end
    if (addr_attr && evt.attr_length >= 16'd4) begin
      port          = xor_attr ? (evt.value[47:32] ^ evt.txid[31:16]) : evt.value[47:32];
      addr_valid[1] = 1'b1;
    end
    if (addr_attr && evt.attr_length >= 16'd8 && evt.value[55:48] == 8'd1) begin
      ipv4          = xor_attr ? (evt.value[31:0] ^ evt.txid) : evt.value[31:0];
      addr_valid[2] = 1'b1;
    end
  end

  assign attr_beat = pack_result(VERDICT_OK, evt.mtype, evt.attr_type, evt.attr_length,
                                 evt.bogus, family, port, ipv4, addr_valid);
  assign evt_verdict_beat = pack_result(evt.verdict, evt.mtype, 16'd0, 16'd0, 1'b0,
                                        8'd0, 16'd0, 32'd0, 3'd0);
  assign pend_verdict_beat = pack_result(pend_code, pend_type, 16'd0, 16'd0, 1'b0,
                                         8'd0, 16'd0, 32'd0, 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      pend_verdict <= 1'b0;
    end else if (load) begin
      if (pend_verdict) begin
        m_tvalid     <= 1'b1;
        pend_verdict <= 1'b0;
      end else if (!empty) begin
        m_tvalid     <= 1'b1;
        pend_verdict <= evt.has_attr && evt.has_verdict;
      end else begin
        m_tvalid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_verdict) begin
        m_tdata <= pend_verdict_beat;
        m_tuser <= KIND_VERDICT;
        m_tlast <= 1'b1;
      end else if (!empty) begin
        pend_type <= evt.mtype;
        pend_code <= evt.verdict;
        if (evt.has_attr) begin
          m_tdata <= attr_beat;
          m_tuser <= KIND_ATTR;
          m_tlast <= !evt.has_verdict;
        end else begin
          m_tdata <= evt_verdict_beat;
          m_tuser <= KIND_VERDICT;
          m_tlast <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/stun_message_parser_top.sv @@
// STUN message parser (classic header, no magic cookie). Feed the datagram
// one byte per transfer on the slave stream, tlast on its final byte. The
// block takes one byte every cycle while the queue is not full: the front
// end does only count, compare and capture work per byte, so a byte is parsed
// in the cycle it is taken. Each byte gives at most two result transfers (an
// attribute record and, on the final byte, the frame verdict); these sit in a
// four-entry queue and the back end sends one transfer per cycle while
// m_tready is high; results pass through the queue and then the registered
// output, and s_tready only drops while the queue is full. Attribute records
// of a frame always come before its verdict; discard them when the verdict
// is not zero. tuser carries the record kind (0 attribute, 1 verdict) and
// tlast marks the final result a byte caused.
module stun_message_parser_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // [7:0] data_byte
  input  logic                         s_tlast,  // frame_last
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [2:0] verdict, [18:3] message_type, [20:19] message_class,
  // [36:21] attr_type, [52:37] attr_length, [53] attr_bogus,
  // [61:54] addr_family, [77:62] addr_port, [109:78] addr_ipv4,
  // [112:110] addr_valid, [119:113] zero
  output logic [stun_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tuser,  // record_kind
  output logic                         m_tlast   // run_last
);
  import stun_pkg::*;

  stun_evt_t push_evt;
  stun_evt_t head_evt;
  logic      push, pop, q_empty, q_full;

  // Front end: parse each byte, push what it caused.
  stun_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .evt      (push_evt)
  );

  // Decouple parsing from output back-pressure.
  stun_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .evt_in  (push_evt),
    .pop     (pop),
    .evt_out (head_evt),
    .empty   (q_empty),
    .full    (q_full)
  );

  // Back end: decode address fields and send records.
  stun_back u_back (
    .clk      (clk),
    .rst      (rst),
    .evt      (head_evt),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/core/stun_checker.sv @@
`include "stun_message_parser_top_defines.svh"

module stun_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [stun_pkg::TDATA_W-1:0] m_tdata,
  input logic                         m_tuser,
  input logic                         m_tlast
);
  import stun_pkg::*;

  `STUN_ASSERT(a_verdict_ends_run, m_tvalid && m_tuser == KIND_VERDICT |-> m_tlast, "verdict without tlast")
  `STUN_ASSERT(a_attr_no_verdict, m_tvalid && m_tuser == KIND_ATTR |-> m_tdata[2:0] == VERDICT_OK, "attribute record carries a verdict")
  `STUN_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
  `STUN_ASSERT_RST(a_reset_idle, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind stun_message_parser_top stun_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
